// ===== src/cellular_automaton_cave_step_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cave step core
// Short forms for clocked implication checks, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_CAVE_STEP_CORE_MACROS_SVH
`define CELLULAR_AUTOMATON_CAVE_STEP_CORE_MACROS_SVH

// Same-cycle implication
`define CACS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cacs: same-cycle check failed");

// Next-cycle implication
`define CACS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cacs: next-cycle check failed");

`endif

// ===== src/cacs_pkg.sv =====
// ---------------------------------------------------------------------------
// Cave step core package
// Sizes, register codes, line store structs and the cell rule.
// ---------------------------------------------------------------------------
package cacs_pkg;

  // Map limits
  localparam int MAX_ROW_LENGTH = 64;
  localparam int MAX_ROW_COUNT  = 1024;

  // Derived widths
  localparam int COL_W     = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W     = $clog2(MAX_ROW_LENGTH + 1);
  localparam int ROWS_W    = $clog2(MAX_ROW_COUNT + 1);
  localparam int IN_ROW_W  = $clog2(MAX_ROW_COUNT + 3);
  localparam int OUT_ROW_W = $clog2(MAX_ROW_COUNT);

  // Register field widths
  localparam int ROW_LENGTH_W = 7;
  localparam int ROW_COUNT_W  = 11;
  localparam int LIMIT_W      = 4;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 2;

  // Register reset values
  localparam logic [ROW_LENGTH_W-1:0] RST_ROW_LENGTH = 7'd64;
  localparam logic [ROW_COUNT_W-1:0]  RST_ROW_COUNT  = 11'd64;
  localparam logic [LIMIT_W-1:0]      RST_SURVIVE    = 4'd4;
  localparam logic [LIMIT_W-1:0]      RST_BIRTH      = 4'd5;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH      = 2'd0,
    REG_ROW_COUNT       = 2'd1,
    REG_SURVIVE_LIMIT   = 2'd2,
    REG_BIRTH_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Request actions
  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Window masks, bit 3*column + row
  localparam logic [8:0] MASK_NEIGHBORS = 9'h1EF;
  localparam logic [8:0] MASK_TOP       = 9'h049;
  localparam logic [8:0] MASK_BOTTOM    = 9'h124;
  localparam logic [8:0] MASK_LEFT      = 9'h007;
  localparam logic [8:0] MASK_RIGHT     = 9'h1C0;

  // Line store write and read groups
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             old_bit;
    logic             new_bit;
  } ls_wr_t;

  typedef struct packed {
    logic old_bit;
    logic new_bit;
  } ls_rd_t;

  // Clamp row length into the supported range
  function automatic logic [LEN_W-1:0] eff_length(input logic [ROW_LENGTH_W-1:0] rl);
    logic [LEN_W-1:0] w;
    if (rl < ROW_LENGTH_W'(3)) begin
      w = LEN_W'(3);
    end else if (int'(rl) > MAX_ROW_LENGTH) begin
      w = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      w = LEN_W'(rl);
    end
    return w;
  endfunction

  // Clamp row count into the supported range
  function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROW_COUNT_W-1:0] rc);
    logic [ROWS_W-1:0] h;
    if (rc < ROW_COUNT_W'(3)) begin
      h = ROWS_W'(3);
    end else if (int'(rc) > MAX_ROW_COUNT) begin
      h = ROWS_W'(MAX_ROW_COUNT);
    end else begin
      h = ROWS_W'(rc);
    end
    return h;
  endfunction

  // Apply the birth/survive rule to a masked window
  function automatic logic next_cell(input logic [8:0] win, input logic [8:0] mask,
                                     input logic [LIMIT_W-1:0] survive,
                                     input logic [LIMIT_W-1:0] birth);
    logic [LIMIT_W-1:0] cnt;
    logic [8:0]         hits;
    logic               alive;
    hits = win & mask;
    cnt  = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + LIMIT_W'(hits[i]);
    end
    if (win[4]) begin
      alive = (cnt >= survive);
    end else begin
      alive = (cnt >= birth);
    end
    return alive;
  endfunction

endpackage

// ===== src/cacs_line_store.sv =====
// ---------------------------------------------------------------------------
// Cave step line store
// Two one-bit row memories with per-entry valid bits, one write port and
// a registered read port that forwards a same-address write.
// ---------------------------------------------------------------------------
`include "cellular_automaton_cave_step_core_macros.svh"

module cacs_line_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cacs_pkg::ls_wr_t          wr,
  input  logic [cacs_pkg::COL_W-1:0] rd_addr,
  output cacs_pkg::ls_rd_t          rd
);
  import cacs_pkg::*;

  logic                      old_mem [MAX_ROW_LENGTH];
  logic                      new_mem [MAX_ROW_LENGTH];
  logic [MAX_ROW_LENGTH-1:0] vld_r;
  ls_rd_t                    rd_r;

  // Write both rows at one column
  always_ff @(posedge clk) begin
    if (wr.en) begin
      old_mem[wr.addr] <= wr.old_bit;
      new_mem[wr.addr] <= wr.new_bit;
    end
  end

  // Mark written columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Prefetch the next column, forward a write to the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
    end else if (wr.en && (wr.addr == rd_addr)) begin
      rd_r <= '{old_bit: wr.old_bit, new_bit: wr.new_bit};
    end else if (vld_r[rd_addr]) begin
      rd_r <= '{old_bit: old_mem[rd_addr], new_bit: new_mem[rd_addr]};
    end else begin
      rd_r <= '0;
    end
  end

  assign rd = rd_r;

  `CACS_ASSERT_NEXT(a_fwd_old, wr.en && (wr.addr == rd_addr), rd_r.old_bit == $past(wr.old_bit))
  `CACS_ASSERT_NEXT(a_fwd_new, wr.en && (wr.addr == rd_addr), rd_r.new_bit == $past(wr.new_bit))
  `CACS_ASSERT_NEXT(a_vld_set, wr.en, vld_r[$past(wr.addr)])

endmodule

// ===== src/cellular_automaton_cave_step_core.sv =====
// Results: each is registered in the output register, or the skid if the output is held;
//   results trail their cells by one row plus one cell of requests.
// Throughput: one request per cycle, set by the registered line store prefetch, unless
//   in_stall holds it; each configuration write raises in_stall to refetch the column.
// Reset (synchronous, rst_n low): clears counters, window, store valid bits,
//   output and skid valids, and loads register defaults.
// ---------------------------------------------------------------------------
// Cave step core
// One birth/death generation over a raster-streamed binary map, with a
// 3x3 window, a two-row line store and a two-entry output buffer.
// ---------------------------------------------------------------------------
`include "cellular_automaton_cave_step_core_macros.svh"

module cellular_automaton_cave_step_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cacs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cacs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic                             in_cell_alive,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_next_alive,
  output logic                             out_frame_end
);
  import cacs_pkg::*;

  // Configuration
  logic [ROW_LENGTH_W-1:0] row_length_r;
  logic [ROW_COUNT_W-1:0]  row_count_r;
  logic [LIMIT_W-1:0]      survive_r;
  logic [LIMIT_W-1:0]      birth_r;
  logic                    cfg_hold_r;

  // Position and window state
  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [8:0]           win_r, win_nxt;

  // Output buffer
  logic out_vld_r, out_alive_r, out_end_r;
  logic skid_vld_r, skid_alive_r, skid_end_r;

  // Step signals
  logic [LEN_W-1:0]  w;
  logic [ROWS_W-1:0] h;
  logic              acc, drain, full, proc, emit, last, cell_bit, res_alive, res_vld;
  logic              at_top, at_bottom, at_left, at_right;
  logic [COL_W-1:0]  col_c, ocol_c, rd_addr;
  logic [LEN_W-1:0]  col_inc, ocol_inc;
  logic [8:0]        win_shift, mask;
  logic              out_take;
  ls_wr_t            ls_wr;
  ls_rd_t            ls_rd;

  cacs_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ls_wr),
    .rd_addr (rd_addr),
    .rd      (ls_rd)
  );

  // Hold input while the skid is full or a column refetch is due
  assign in_stall = skid_vld_r || cfg_hold_r;
  assign acc      = in_valid && !in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= RST_ROW_LENGTH;
      row_count_r  <= RST_ROW_COUNT;
      survive_r    <= RST_SURVIVE;
      birth_r      <= RST_BIRTH;
      cfg_hold_r   <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ROW_LENGTH:      row_length_r <= cfg_data[ROW_LENGTH_W-1:0];
          REG_ROW_COUNT:       row_count_r  <= cfg_data[ROW_COUNT_W-1:0];
          REG_SURVIVE_LIMIT:   survive_r    <= cfg_data[LIMIT_W-1:0];
          REG_BIRTH_THRESHOLD: birth_r      <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Decode one request
  always_comb begin
    w        = eff_length(row_length_r);
    h        = eff_rows(row_count_r);
    col_c    = (LEN_W'(in_col_r) >= w) ? '0 : in_col_r;
    ocol_c   = (LEN_W'(out_col_r) >= w) ? '0 : out_col_r;
    drain    = (in_action == ACT_DRAIN);
    full     = (in_row_r >= IN_ROW_W'(h));
    proc     = drain ? full : !full;
    cell_bit = drain ? 1'b0 : in_cell_alive;
    emit     = (in_row_r >= IN_ROW_W'(2)) || ((in_row_r == IN_ROW_W'(1)) && (col_c != '0));

    win_shift = {cell_bit, ls_rd.new_bit, ls_rd.old_bit, win_r[8:3]};

    // Mask off-map neighbors
    at_top    = (out_row_r == '0);
    at_bottom = (ROWS_W'(out_row_r) + ROWS_W'(1) >= h);
    at_left   = (ocol_c == '0);
    at_right  = (LEN_W'(ocol_c) + LEN_W'(1) >= w);
    mask      = MASK_NEIGHBORS;
    if (at_top)    mask = mask & ~MASK_TOP;
    if (at_bottom) mask = mask & ~MASK_BOTTOM;
    if (at_left)   mask = mask & ~MASK_LEFT;
    if (at_right)  mask = mask & ~MASK_RIGHT;

    res_alive = next_cell(win_shift, mask, survive_r, birth_r);
    last      = at_bottom && at_right;
    res_vld   = acc && proc && emit;

    col_inc  = LEN_W'(col_c) + LEN_W'(1);
    ocol_inc = LEN_W'(ocol_c) + LEN_W'(1);

    // Advance positions
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    win_nxt     = win_r;
    if (acc) begin
      in_col_nxt  = col_c;
      out_col_nxt = ocol_c;
      if (proc) begin
        win_nxt = win_shift;
        if (col_inc >= w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + IN_ROW_W'(1);
        end else begin
          in_col_nxt = col_inc[COL_W-1:0];
        end
        if (emit) begin
          if (last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (ocol_inc >= w) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + OUT_ROW_W'(1);
          end else begin
            out_col_nxt = ocol_inc[COL_W-1:0];
          end
        end
      end
    end

    // Shift rows down the line store and prefetch the next column
    ls_wr.en      = acc && proc;
    ls_wr.addr    = col_c;
    ls_wr.old_bit = ls_rd.new_bit;
    ls_wr.new_bit = cell_bit;
    rd_addr       = (LEN_W'(in_col_nxt) >= w) ? '0 : in_col_nxt;
  end

  // Hold position and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      win_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      win_r     <= win_nxt;
    end
  end

  // Output register with a skid stage behind it
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_vld_r && !out_take) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_alive_r <= skid_alive_r;
        out_end_r   <= skid_end_r;
      end
    end else if (res_vld) begin
      if (out_vld_r && !out_take) begin
        skid_alive_r <= res_alive;
        skid_end_r   <= last;
      end else begin
        out_alive_r <= res_alive;
        out_end_r   <= last;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_next_alive = out_alive_r;
  assign out_frame_end  = out_end_r;

  `CACS_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r)
  `CACS_ASSERT_NEXT(a_frame_restart, res_vld && last, (in_row_r == '0) && (out_row_r == '0) && (out_col_r == '0))
  `CACS_ASSERT_NEXT(a_ignored_keeps_window, acc && !proc, $stable(win_r))

endmodule

// ===== verif/cellular_automaton_cave_step_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cave step core testbench
// Streams binary maps through the core under random flow control, predicts
// each next-generation cell with a line-buffer model of the birth/death rule
// and checks every result in order.
// ---------------------------------------------------------------------------
module cellular_automaton_cave_step_core_tb;
  import cacs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_SLACK     = 8;
  localparam int RANDOM_REQUESTS = 250;

  // Neighborhood masks, bit 3*column + row, column 0 oldest, row 0 top
  localparam logic [8:0] NBR_ALL     = 9'h1EF;
  localparam logic [8:0] EDGE_TOP    = 9'h049;
  localparam logic [8:0] EDGE_BOTTOM = 9'h124;
  localparam logic [8:0] EDGE_LEFT   = 9'h007;
  localparam logic [8:0] EDGE_RIGHT  = 9'h1C0;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  typedef struct packed {
    logic next_alive;
    logic frame_end;
  } cell_result_t;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic                   in_action     = ACT_CELL;
  logic                   in_cell_alive = 1'b0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic                   out_next_alive;
  logic                   out_frame_end;

  // Model state: registers, line stores, window and raster positions
  logic [ROW_LENGTH_W-1:0] len_cfg;
  logic [ROW_COUNT_W-1:0]  rows_cfg;
  logic [LIMIT_W-1:0]      survive_cfg;
  logic [LIMIT_W-1:0]      birth_cfg;
  logic                    older_line [MAX_ROW_LENGTH];
  logic                    newer_line [MAX_ROW_LENGTH];
  logic [8:0]              nbhd;
  logic [6:0]              feed_col;
  logic [10:0]             feed_row;
  logic [6:0]              emit_col;
  logic [10:0]             emit_row;

  cell_result_t expected_cells[$];
  int unsigned  effective_requests = 0;
  int unsigned  mismatches         = 0;

  // Flow control state
  bit           tx_bursty       = 1'b1;
  int unsigned  tx_burst_left   = 0;
  int unsigned  rx_hold_request = 0;
  int unsigned  rx_hold_left    = 0;
  int unsigned  rx_mode_left    = 0;
  int unsigned  rx_period       = 2;
  int unsigned  rx_phase        = 0;
  rx_pattern_t  rx_mode         = RX_FLOW;
  int unsigned  quiet_cycles    = 0;

  cellular_automaton_cave_step_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_cell_alive (in_cell_alive),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_alive(out_next_alive),
    .out_frame_end (out_frame_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamped map size as the core uses it
  function automatic int unsigned map_width();
    if (len_cfg < 3) return 3;
    if (len_cfg > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
    return len_cfg;
  endfunction

  function automatic int unsigned map_height();
    if (rows_cfg < 3) return 3;
    if (rows_cfg > MAX_ROW_COUNT) return MAX_ROW_COUNT;
    return rows_cfg;
  endfunction

  // All cells of the frame are in; only drain requests advance it now
  function automatic bit map_full();
    return feed_row >= map_height();
  endfunction

  function automatic int unsigned pick_limit();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
  endfunction

  task automatic model_reset();
    len_cfg     = 7'd64;
    rows_cfg    = 11'd64;
    survive_cfg = 4'd4;
    birth_cfg   = 4'd5;
    for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
      older_line[i] = 1'b0;
      newer_line[i] = 1'b0;
    end
    nbhd     = '0;
    feed_col = '0;
    feed_row = '0;
    emit_col = '0;
    emit_row = '0;
  endtask

  // Advance the model by one accepted request and queue the cell it yields
  task automatic predict_request(input logic action, input logic alive);
    int unsigned w;
    int unsigned h;
    int unsigned count;
    logic        bit_in;
    logic        emit;
    logic        fate;
    logic        last;
    logic [2:0]  column;
    logic [8:0]  mask;
    w = map_width();
    h = map_height();
    if (feed_col >= w) feed_col = '0;
    if (emit_col >= w) emit_col = '0;
    // Drop drains before the frame is complete and cells after it
    if ((action == ACT_DRAIN) != (feed_row >= h)) return;
    bit_in = (action == ACT_CELL) ? alive : 1'b0;
    emit   = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
    column = {bit_in, newer_line[feed_col], older_line[feed_col]};
    nbhd   = {column, nbhd[8:3]};
    older_line[feed_col] = newer_line[feed_col];
    newer_line[feed_col] = bit_in;
    effective_requests++;
    feed_col++;
    if (feed_col >= w) begin
      feed_col = '0;
      feed_row++;
    end
    if (!emit) return;
    // Cells off the map count as dead
    mask = NBR_ALL;
    if (emit_row == 0) mask &= ~EDGE_TOP;
    if (emit_row + 1 >= h) mask &= ~EDGE_BOTTOM;
    if (emit_col == 0) mask &= ~EDGE_LEFT;
    if (emit_col + 1 >= w) mask &= ~EDGE_RIGHT;
    count = $countones(nbhd & mask);
    fate  = nbhd[4] ? (count >= survive_cfg) : (count >= birth_cfg);
    last  = (emit_row + 1 >= h) && (emit_col + 1 >= w);
    expected_cells.push_back('{next_alive: fate, frame_end: last});
    if (last) begin
      feed_col = '0;
      feed_row = '0;
      emit_col = '0;
      emit_row = '0;
    end else begin
      emit_col++;
      if (emit_col >= w) begin
        emit_col = '0;
        emit_row++;
      end
    end
  endtask

  // Wait for every expected cell, then for the pipeline to empty
  task automatic settle();
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_ROW_LENGTH:      len_cfg     = value[ROW_LENGTH_W-1:0];
      REG_ROW_COUNT:       rows_cfg    = value[ROW_COUNT_W-1:0];
      REG_SURVIVE_LIMIT:   survive_cfg = value[LIMIT_W-1:0];
      REG_BIRTH_THRESHOLD: birth_cfg   = value[LIMIT_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Write all four registers once idle; unused upper data bits carry noise
  task automatic configure_map(input int unsigned len, input int unsigned rows,
                               input int unsigned survive, input int unsigned birth);
    settle();
    write_reg(REG_ROW_LENGTH, CFG_DATA_W'({$urandom(), ROW_LENGTH_W'(len)}));
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(REG_SURVIVE_LIMIT, CFG_DATA_W'({$urandom(), LIMIT_W'(survive)}));
    write_reg(REG_BIRTH_THRESHOLD, CFG_DATA_W'({$urandom(), LIMIT_W'(birth)}));
  endtask

  // Offer one request, hold it until accepted, then drop valid
  task automatic send_request(input logic action, input logic alive);
    if (tx_bursty) begin
      if (tx_burst_left == 0) begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
        tx_burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 16);
      end
      tx_burst_left--;
    end
    in_action     = action;
    in_cell_alive = alive;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(action, alive);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Feed cells until the frame is full, then drain it; stop early if asked
  task automatic run_frame(input int unsigned density, input int unsigned noise,
                           input int stop_after);
    int sent;
    sent = 0;
    while (!map_full() && sent != stop_after) begin
      if ($urandom_range(0, 99) < noise) send_request(ACT_DRAIN, 1'($urandom));
      send_request(ACT_CELL, $urandom_range(0, 99) < density);
      sent++;
    end
    if (sent == stop_after) return;
    while (map_full()) begin
      if ($urandom_range(0, 99) < noise) send_request(ACT_CELL, 1'($urandom));
      send_request(ACT_DRAIN, 1'($urandom));
    end
  endtask

  // Smallest map: ignored drain and cell, a birth at full count, stray drain
  task automatic test_directed_frame();
    logic [8:0] pattern;
    pattern = 9'b111_101_111;
    configure_map(3, 3, 0, 8);
    send_request(ACT_DRAIN, 1'b1);
    for (int i = 0; i < 9; i++) send_request(ACT_CELL, pattern[i]);
    send_request(ACT_CELL, 1'b1);
    repeat (4) send_request(ACT_DRAIN, 1'b0);
    send_request(ACT_DRAIN, 1'b0);
  endtask

  // Hold the result side long enough to back up the input, with sender pauses off
  task automatic test_backpressure();
    configure_map(8, 6, 4, 4);
    tx_bursty       = 1'b0;
    rx_hold_request = 400;
    run_frame(50, 0, 24);
    settle();
    run_frame(50, 0, -1);
    tx_bursty = 1'b1;
  endtask

  task automatic test_wide_rows();
    configure_map(64, 3, 8, 0);
    run_frame(50, 5, -1);
  endtask

  // Shrink the map in the middle of an oversized frame
  task automatic test_midframe_resize();
    configure_map(127, 2047, 9, 15);
    run_frame(60, 0, 150);
    configure_map(5, 4, 3, 2);
    run_frame(50, 0, -1);
  endtask

  task automatic test_tall_map();
    configure_map(3, 50, 3, 5);
    run_frame(45, 0, -1);
  endtask

  // Mostly small complete frames, some abandoned ones and stray requests
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    int unsigned rows;
    int          stop;
    goal = effective_requests + RANDOM_REQUESTS;
    while (effective_requests < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        len  = $urandom_range(65, 127);
        rows = $urandom_range(0, 3);
      end else if (pick < 14) begin
        len  = $urandom_range(0, 2);
        rows = $urandom_range(0, 2);
      end else if (pick < 24) begin
        len  = $urandom_range(9, 16);
        rows = $urandom_range(3, 8);
      end else begin
        len  = $urandom_range(3, 8);
        rows = $urandom_range(3, 6);
      end
      configure_map(len, rows, pick_limit(), pick_limit());
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3 * map_width()) : -1;
      run_frame($urandom_range(0, 100), ($urandom_range(0, 3) == 0) ? 10 : 0, stop);
      if ($urandom_range(0, 4) == 0) send_request(ACT_DRAIN, 1'($urandom));
    end
  endtask

  // Result-side stall: long holds first, otherwise a pattern that changes mode
  always @(negedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_pattern_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
      rx_period    = $urandom_range(2, 7);
    end
    rx_mode_left--;
    rx_phase++;
    if (rx_hold_left != 0) begin
      out_stall = 1'b1;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_FLOW:  out_stall = 1'b0;
        RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
        default:  out_stall = ((rx_phase % rx_period) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expected cell
  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual next_alive=%0b frame_end=%0b",
                 $time, out_next_alive, out_frame_end);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (out_next_alive !== want.next_alive) begin
          $display("%0t: next_alive expected %0b actual %0b",
                   $time, want.next_alive, out_next_alive);
          mismatches++;
        end
        if (out_frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, want.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_frame();
    test_backpressure();
    test_wide_rows();
    test_midframe_resize();
    test_tall_map();
    test_random_frames();
    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cacs_pkg.sv
src/cacs_line_store.sv
src/cellular_automaton_cave_step_core.sv
verif/cellular_automaton_cave_step_core_tb.sv
